// ===== rtl/core/bvm_pkg.sv =====
// Shared types, constants and battery voltage tables for the battery voltage monitor.
package bvm_pkg;

  localparam int unsigned SampleW = 16;   // sample and filtered output, mV
  localparam int unsigned StateW  = 32;   // filter state, 16.16 mV
  localparam int unsigned GainW   = 16;   // Q0.16 gain
  localparam int unsigned TypeW   = 3;
  localparam int unsigned LevelW  = 15;
  localparam int unsigned VoltW   = 15;   // pack voltages up to 16800 mV
  localparam int unsigned SpanW   = 12;   // full - low, up to 4000 mV
  localparam int unsigned NumW    = 23;   // (|diff| * 100) >> 16
  localparam int unsigned QuotW   = 16;
  localparam int unsigned RemW    = 12;
  localparam int unsigned CfgIdxW = 1;

  // Divider: quotient bits retired per cycle and cycles per division
  localparam int unsigned DivBitsPerCyc = 4;
  localparam int unsigned DivCycles     = QuotW / DivBitsPerCyc;
  localparam int unsigned DivCntW       = $clog2(DivCycles);

  localparam int unsigned QueueDepthDef = 2;

  localparam logic [TypeW-1:0] TypeReset = 3'd0;
  localparam logic [GainW-1:0] GainReset = 16'd62259;

  localparam logic [CfgIdxW-1:0] CfgBatteryType = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgFilterGain  = 1'b1;

  localparam logic signed [LevelW-1:0] LevelMin = -15'sd1024;
  localparam logic signed [LevelW-1:0] LevelMax = 15'sd16383;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIFF,
    ST_SCALE,
    ST_DIV,
    ST_HOLD
  } bvm_state_e;

  typedef struct packed {
    logic [TypeW-1:0] battery_type;
    logic [GainW-1:0] filter_gain;
    logic             reload;
    logic [TypeW-1:0] reload_type;
  } bvm_cfg_t;

  typedef struct packed {
    logic               valid;
    logic [SampleW-1:0] sample;
  } bvm_head_t;

  // Full pack voltage: LiPo 4200 mV/cell, LiFe 3600 mV/cell
  function automatic logic [VoltW-1:0] full_mv(input logic [TypeW-1:0] t);
    logic [VoltW-1:0] v;
    case (t)
      3'd0:    v = 15'd4200;
      3'd1:    v = 15'd8400;
      3'd2:    v = 15'd12600;
      3'd3:    v = 15'd16800;
      3'd4:    v = 15'd3600;
      3'd5:    v = 15'd7200;
      3'd6:    v = 15'd10800;
      3'd7:    v = 15'd14400;
      default: v = 15'd4200;
    endcase
    return v;
  endfunction

  // Low pack voltage: LiPo 3200 mV/cell, LiFe 3000 mV/cell
  function automatic logic [VoltW-1:0] low_mv(input logic [TypeW-1:0] t);
    logic [VoltW-1:0] v;
    case (t)
      3'd0:    v = 15'd3200;
      3'd1:    v = 15'd6400;
      3'd2:    v = 15'd9600;
      3'd3:    v = 15'd12800;
      3'd4:    v = 15'd3000;
      3'd5:    v = 15'd6000;
      3'd6:    v = 15'd9000;
      3'd7:    v = 15'd12000;
      default: v = 15'd3200;
    endcase
    return v;
  endfunction

  // full - low
  function automatic logic [SpanW-1:0] span_mv(input logic [TypeW-1:0] t);
    logic [SpanW-1:0] v;
    case (t)
      3'd0:    v = 12'd1000;
      3'd1:    v = 12'd2000;
      3'd2:    v = 12'd3000;
      3'd3:    v = 12'd4000;
      3'd4:    v = 12'd600;
      3'd5:    v = 12'd1200;
      3'd6:    v = 12'd1800;
      3'd7:    v = 12'd2400;
      default: v = 12'd1000;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/battery_voltage_monitor.sv =====
// Top level of the battery voltage monitor: configuration registers, front queue, filter back end.
//
// Usage
//   Input channel (in_valid_i / in_ready_o / sample_mv_i): one battery voltage sample
//   in mV per transaction. Samples go into a small queue (QueueDepth entries), so
//   in_ready_o only drops when that queue is full.
//   Output channel (out_valid_o / out_ready_i): one result per sample: filtered_mv_o
//   (integer mV of the 16.16 filter state), level_percent_o (signed percent,
//   truncated toward zero, clamped to -1024..16383) and is_low_o.
//   Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i.
//   Index 0 is battery_type (LiPo 1S..4S, LiFe 1S..4S) and reloads the filter to the
//   full voltage; index 1 is filter_gain (Q0.16). Write only while the block is idle.
// Processing
//   The back end handles one sample at a time: two multiplies, the sum, the compare
//   against the low voltage, the scale-by-100 multiply and the 4-bit per cycle
//   divider that forms the charge level. It pops the next sample from the queue only
//   after the previous result has been loaded into the result register.
// Reset
//   Type LiPo 1S, gain 62259, filter at 4200 mV, queue and result register empty.
//   If the receiver stalls, the result is held, the back end waits with the next
//   result ready, and the queue keeps taking samples until it fills.
module battery_voltage_monitor #(
  parameter int unsigned QueueDepth = bvm_pkg::QueueDepthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bvm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bvm_pkg::GainW-1:0]    cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [bvm_pkg::SampleW-1:0]  sample_mv_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [bvm_pkg::SampleW-1:0]  filtered_mv_o,
  output logic [bvm_pkg::LevelW-1:0]   level_percent_o,
  output logic                         is_low_o
);

  logic [bvm_pkg::TypeW-1:0] type_q, type_d;
  logic [bvm_pkg::GainW-1:0] gain_q, gain_d;
  logic                      type_wr;
  bvm_pkg::bvm_cfg_t         cfg;
  bvm_pkg::bvm_head_t        head;
  logic                      pop;

  // Register decode; a type write also reloads the filter state in the back end
  always_comb begin
    type_d  = type_q;
    gain_d  = gain_q;
    type_wr = 1'b0;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        bvm_pkg::CfgBatteryType: begin
          type_d  = cfg_data_i[bvm_pkg::TypeW-1:0];
          type_wr = 1'b1;
        end
        bvm_pkg::CfgFilterGain: begin
          gain_d = cfg_data_i;
        end
        default: begin
          type_d = type_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_q <= bvm_pkg::TypeReset;
      gain_q <= bvm_pkg::GainReset;
    end else begin
      type_q <= type_d;
      gain_q <= gain_d;
    end
  end

  assign cfg.battery_type = type_q;
  assign cfg.filter_gain  = gain_q;
  assign cfg.reload       = type_wr;
  assign cfg.reload_type  = cfg_data_i[bvm_pkg::TypeW-1:0];

  bvm_front #(
    .Depth (QueueDepth)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sample_i   (sample_mv_i),
    .pop_i      (pop),
    .head_o     (head)
  );

  bvm_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .head_i          (head),
    .pop_o           (pop),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .filtered_mv_o   (filtered_mv_o),
    .level_percent_o (level_percent_o),
    .is_low_o        (is_low_o)
  );

endmodule

// ===== rtl/core/bvm_front.sv =====
// Front end: accepts sample transactions into a small queue ahead of the filter.
module bvm_front #(
  parameter int unsigned Depth = bvm_pkg::QueueDepthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [bvm_pkg::SampleW-1:0] sample_i,
  input  logic                        pop_i,
  output bvm_pkg::bvm_head_t          head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [bvm_pkg::SampleW-1:0] mem_q [Depth];
  logic [PtrW-1:0]             wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]             rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]             cnt_q, cnt_d;
  logic                        push;

  assign in_ready_o    = (cnt_q != CntW'(Depth));
  assign push          = in_valid_i && in_ready_o;
  assign head_o.valid  = (cnt_q != '0);
  assign head_o.sample = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= sample_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntW'(Depth))
    else $error("queue count above depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> head_o.valid)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop_i) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count lost a push");

endmodule

// ===== rtl/core/bvm_div.sv =====
// Multi-cycle restoring divider, four quotient bits per cycle.
module bvm_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [bvm_pkg::NumW-1:0]  num_i,
  input  logic [bvm_pkg::SpanW-1:0] den_i,
  output logic                      done_o,
  output logic [bvm_pkg::QuotW-1:0] quot_o
);

  localparam int unsigned HiW = bvm_pkg::NumW - bvm_pkg::QuotW;

  logic                        busy_q;
  logic                        done_q;
  logic [bvm_pkg::DivCntW-1:0] cnt_q;
  logic [bvm_pkg::RemW-1:0]    rem_q, rem_n;
  logic [bvm_pkg::QuotW-1:0]   sh_q, sh_n;
  logic [bvm_pkg::SpanW-1:0]   den_q;
  logic [bvm_pkg::RemW:0]      trial;

  // Numerator bits shift out of sh at the top, quotient bits shift in at the bottom.
  always_comb begin
    rem_n = rem_q;
    sh_n  = sh_q;
    trial = '0;
    for (int i = 0; i < int'(bvm_pkg::DivBitsPerCyc); i++) begin
      trial = {rem_n, sh_n[bvm_pkg::QuotW-1]};
      sh_n  = {sh_n[bvm_pkg::QuotW-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        trial   = trial - {1'b0, den_q};
        sh_n[0] = 1'b1;
      end
      rem_n = trial[bvm_pkg::RemW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == bvm_pkg::DivCntW'(bvm_pkg::DivCycles - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Quotient fits QuotW bits, so the top numerator bits are already below den.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= bvm_pkg::RemW'(num_i[bvm_pkg::NumW-1 -: HiW]);
      sh_q  <= num_i[bvm_pkg::QuotW-1:0];
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_n;
      sh_q  <= sh_n;
    end
  end

  assign done_o = done_q;
  assign quot_o = sh_q;

endmodule

// ===== rtl/core/bvm_back.sv =====
// Back end: low-pass filter update, charge level division and result register.
module bvm_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bvm_pkg::bvm_cfg_t            cfg_i,
  input  bvm_pkg::bvm_head_t           head_i,
  output logic                         pop_o,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [bvm_pkg::SampleW-1:0]  filtered_mv_o,
  output logic [bvm_pkg::LevelW-1:0]   level_percent_o,
  output logic                         is_low_o
);

  localparam int unsigned ProdAW  = bvm_pkg::GainW + bvm_pkg::StateW;
  localparam int unsigned WgtW    = bvm_pkg::GainW + 1;
  localparam int unsigned ProdBW  = WgtW + bvm_pkg::SampleW;
  localparam int unsigned SumW    = ProdBW + 1;
  localparam int unsigned DiffW   = bvm_pkg::StateW + 1;
  localparam int unsigned ScaleW  = bvm_pkg::StateW + 7;
  localparam int unsigned FracW   = 16;

  bvm_pkg::bvm_state_e state_q, state_d;

  logic [bvm_pkg::StateW-1:0]  filt_q, filt_d;
  logic [ProdAW-1:0]           prod_a_q;
  logic [ProdBW-1:0]           prod_b_q;
  logic [bvm_pkg::StateW-1:0]  mag_q;
  logic                        neg_q;
  logic [WgtW-1:0]             wgt;
  logic [SumW-1:0]             sum;
  logic [DiffW-1:0]            diff;
  logic [ScaleW-1:0]           scaled;
  logic                        div_start;
  logic                        div_done;
  logic [bvm_pkg::QuotW-1:0]   quot;
  logic                        load;
  logic [bvm_pkg::LevelW-1:0]  level;

  logic                        out_valid_q;
  logic [bvm_pkg::SampleW-1:0] out_filt_q;
  logic [bvm_pkg::LevelW-1:0]  out_level_q;
  logic                        out_low_q;

  // new = (65536 - g) * sample + floor(g * old / 65536)
  assign wgt    = WgtW'(17'h10000) - WgtW'(cfg_i.filter_gain);
  assign sum    = SumW'(prod_b_q) + SumW'(prod_a_q[ProdAW-1:FracW]);
  assign diff   = {1'b0, filt_q}
                - DiffW'({bvm_pkg::low_mv(cfg_i.battery_type), 16'h0000});
  assign scaled = ScaleW'(mag_q) * ScaleW'(100);

  always_comb begin
    if (neg_q) begin
      level = (quot > bvm_pkg::QuotW'(1024)) ? bvm_pkg::LevelMin
                                               : bvm_pkg::LevelW'(0) - quot[bvm_pkg::LevelW-1:0];
    end else begin
      level = (quot > bvm_pkg::QuotW'(bvm_pkg::LevelMax)) ? bvm_pkg::LevelMax
                                                           : quot[bvm_pkg::LevelW-1:0];
    end
  end

  always_comb begin
    state_d   = state_q;
    pop_o     = 1'b0;
    div_start = 1'b0;
    load      = 1'b0;
    case (state_q)
      bvm_pkg::ST_IDLE: begin
        if (head_i.valid) begin
          pop_o   = 1'b1;
          state_d = bvm_pkg::ST_SUM;
        end
      end
      bvm_pkg::ST_SUM: begin
        state_d = bvm_pkg::ST_DIFF;
      end
      bvm_pkg::ST_DIFF: begin
        state_d = bvm_pkg::ST_SCALE;
      end
      bvm_pkg::ST_SCALE: begin
        div_start = 1'b1;
        state_d   = bvm_pkg::ST_DIV;
      end
      bvm_pkg::ST_DIV: begin
        if (div_done) begin
          if (!out_valid_q || out_ready_i) begin
            load    = 1'b1;
            state_d = bvm_pkg::ST_IDLE;
          end else begin
            state_d = bvm_pkg::ST_HOLD;
          end
        end
      end
      bvm_pkg::ST_HOLD: begin
        if (!out_valid_q || out_ready_i) begin
          load    = 1'b1;
          state_d = bvm_pkg::ST_IDLE;
        end
      end
      default: state_d = bvm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    filt_d = filt_q;
    if (cfg_i.reload) begin
      filt_d = bvm_pkg::StateW'({bvm_pkg::full_mv(cfg_i.reload_type), 16'h0000});
    end else if (state_q == bvm_pkg::ST_SUM) begin
      filt_d = sum[bvm_pkg::StateW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bvm_pkg::ST_IDLE;
      filt_q      <= bvm_pkg::StateW'({bvm_pkg::full_mv(bvm_pkg::TypeReset), 16'h0000});
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      filt_q  <= filt_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      prod_a_q <= ProdAW'(cfg_i.filter_gain) * ProdAW'(filt_q);
      prod_b_q <= ProdBW'(wgt) * ProdBW'(head_i.sample);
    end
    // Filter state is final after ST_SUM: sign and magnitude of the distance to low voltage
    if (state_q == bvm_pkg::ST_DIFF) begin
      neg_q <= diff[DiffW-1];
      mag_q <= diff[DiffW-1] ? bvm_pkg::StateW'(-diff) : diff[bvm_pkg::StateW-1:0];
    end
    if (load) begin
      out_filt_q  <= filt_q[bvm_pkg::StateW-1 -: bvm_pkg::SampleW];
      out_level_q <= level;
      out_low_q   <= neg_q;
    end
  end

  bvm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (scaled[ScaleW-1 -: bvm_pkg::NumW]),
    .den_i   (bvm_pkg::span_mv(cfg_i.battery_type)),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  assign out_valid_o     = out_valid_q;
  assign filtered_mv_o   = out_filt_q;
  assign level_percent_o = out_level_q;
  assign is_low_o        = out_low_q;

endmodule

// ===== verif/bvm_reading_checker.sv =====
// Reading checker for the battery voltage monitor: tracks registers, predicts readings, compares.
module bvm_reading_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bvm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [bvm_pkg::GainW-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic [bvm_pkg::SampleW-1:0] sample_mv_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic [bvm_pkg::SampleW-1:0] filtered_mv_i,
  input  logic [bvm_pkg::LevelW-1:0]  level_percent_i,
  input  logic                        is_low_i,
  output int unsigned                 mismatch_cnt_o,
  output int unsigned                 pending_o,
  output int unsigned                 checked_cnt_o
);

  localparam logic [bvm_pkg::GainW-1:0] GainAtReset = 16'd62259;
  localparam longint                    PctMin      = -1024;
  localparam longint                    PctMax      = 16383;
  localparam int unsigned               ReportCap   = 40;

  typedef struct packed {
    logic [bvm_pkg::SampleW-1:0] mv;
    logic [bvm_pkg::LevelW-1:0]  pct;
    logic                        low;
  } reading_t;

  logic [bvm_pkg::TypeW-1:0]  pack_type;
  logic [bvm_pkg::GainW-1:0]  ema_gain;
  logic [bvm_pkg::StateW-1:0] ema_state;   // 16.16 mV
  reading_t                   expected_readings_q[$];
  int unsigned                mismatches;
  int unsigned                checked;

  function automatic int unsigned pack_full_mv(input logic [bvm_pkg::TypeW-1:0] t);
    return (int'(t[1:0]) + 1) * (t[2] ? 3600 : 4200);
  endfunction

  function automatic int unsigned pack_low_mv(input logic [bvm_pkg::TypeW-1:0] t);
    return (int'(t[1:0]) + 1) * (t[2] ? 3000 : 3200);
  endfunction

  task automatic report_field(input string name, input longint want, input longint got);
    if (mismatches < ReportCap)
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    logic [63:0] acc;
    longint      diff;
    longint      span;
    longint      pct;
    int unsigned full_v;
    int unsigned low_v;
    reading_t    want;
    reading_t    got;
    if (!rst_ni) begin
      pack_type  = '0;
      ema_gain   = GainAtReset;
      ema_state  = 32'(pack_full_mv('0)) << 16;
      expected_readings_q.delete();
      mismatches = 0;
      checked    = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == bvm_pkg::CfgBatteryType) begin
          // type write also reloads the filter to the new full voltage
          pack_type = cfg_data_i[bvm_pkg::TypeW-1:0];
          ema_state = 32'(pack_full_mv(pack_type)) << 16;
        end else if (cfg_idx_i == bvm_pkg::CfgFilterGain) begin
          ema_gain = cfg_data_i;
        end
      end

      if (out_valid_i && out_ready_i) begin
        got = '{filtered_mv_i, level_percent_i, is_low_i};
        if (expected_readings_q.size() == 0) begin
          if (mismatches < ReportCap)
            $display("%0t: unexpected reading, expected none, actual mv=%0d pct=%0d low=%0b",
                     $time, got.mv, $signed(got.pct), got.low);
          mismatches++;
        end else begin
          want = expected_readings_q.pop_front();
          checked++;
          if (got.mv != want.mv) report_field("filtered_mv", want.mv, got.mv);
          if (got.pct != want.pct)
            report_field("level_percent", $signed(want.pct), $signed(got.pct));
          if (got.low != want.low) report_field("is_low", want.low, got.low);
        end
      end

      if (in_valid_i && in_ready_i) begin
        // exact 48-bit blend, floor on the shift
        acc = 64'(ema_gain) * 64'(ema_state)
            + (64'd65536 - 64'(ema_gain)) * (64'(sample_mv_i) << 16);
        ema_state = acc[47:16];
        full_v = pack_full_mv(pack_type);
        low_v  = pack_low_mv(pack_type);
        diff = longint'(ema_state) - (longint'(low_v) <<< 16);
        span = longint'(full_v - low_v) <<< 16;
        pct  = (diff * 100) / span;   // truncates toward zero
        if (pct < PctMin) pct = PctMin;
        if (pct > PctMax) pct = PctMax;
        want.mv  = ema_state[31:16];
        want.pct = pct[bvm_pkg::LevelW-1:0];
        want.low = (ema_state < (low_v << 16));
        expected_readings_q.push_back(want);
      end
    end
    mismatch_cnt_o <= mismatches;
    pending_o      <= expected_readings_q.size();
    checked_cnt_o  <= checked;
  end

endmodule

// ===== verif/tb_battery_voltage_monitor.sv =====
// Top of the battery voltage monitor testbench: clock, reset, stimulus, stalls and verdict.
module tb_battery_voltage_monitor;

  localparam int unsigned QuietLimit = 4000;  // cycles without any transaction
  localparam int unsigned HoldCycles = 300;   // long output back-pressure stretch
  localparam int unsigned SegItems   = 50;

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [bvm_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [bvm_pkg::GainW-1:0]   cfg_data_i;
  logic                        in_valid_i;
  logic                        in_ready_o;
  logic [bvm_pkg::SampleW-1:0] sample_mv_i;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic [bvm_pkg::SampleW-1:0] filtered_mv_o;
  logic [bvm_pkg::LevelW-1:0]  level_percent_o;
  logic                        is_low_o;

  int unsigned mismatch_cnt;
  int unsigned pending;
  int unsigned checked_cnt;

  // handshake mix, set per phase
  int unsigned idle_pct  = 0;   // sender: chance per cycle of staying idle
  int unsigned stall_pct = 0;   // receiver: chance per cycle of ready low

  // long hold-off request: the stimulus toggles it, the receiver counts it out
  logic        hold_req  = 1'b0;
  logic        hold_seen = 1'b0;
  int unsigned hold_left = 0;

  int unsigned n_sent   = 0;
  int unsigned n_writes = 0;
  int unsigned quiet    = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  battery_voltage_monitor dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_mv_i    (sample_mv_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .filtered_mv_o  (filtered_mv_o),
    .level_percent_o(level_percent_o),
    .is_low_o       (is_low_o)
  );

  bvm_reading_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .sample_mv_i    (sample_mv_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .filtered_mv_i  (filtered_mv_o),
    .level_percent_i(level_percent_o),
    .is_low_i       (is_low_o),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending),
    .checked_cnt_o  (checked_cnt)
  );

  // Receiver: random stalls, or a long hold-off while the sender keeps pushing,
  // which fills the input queue and drops in_ready_o.
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen   <= hold_req;
      hold_left   <= HoldCycles;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: any transaction on either channel restarts the count.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet <= 0;
    end else if (quiet >= QuietLimit) begin
      $display("watchdog: no transaction for %0d cycles, %0d readings outstanding",
               quiet, pending);
      $display("battery_voltage_monitor regression: fail");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // One sample transaction. Idle gap first, so valid is never dropped and
  // raised in the same step; then hold valid and payload until accepted.
  task automatic send_sample(input logic [bvm_pkg::SampleW-1:0] mv);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    sample_mv_i <= mv;
    do @(posedge clk_i); while (!in_ready_o);
    n_sent++;
  endtask

  // Stop sending and wait until every predicted reading has been taken.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Register write: one enable cycle, then the enable is dropped before the task returns.
  task automatic write_reg(input logic [bvm_pkg::CfgIdxW-1:0] idx,
                           input logic [bvm_pkg::GainW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    n_writes++;
  endtask

  initial begin
    int unsigned                 sender_idle[4];
    int unsigned                 recv_stall[4];
    int unsigned                 roll;
    logic [bvm_pkg::SampleW-1:0] mv;
    logic [bvm_pkg::GainW-1:0]   gain;

    sender_idle = '{0, 86, 0, 33};
    recv_stall  = '{0, 0, 86, 33};
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = bvm_pkg::CfgBatteryType;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    sample_mv_i = '0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed ----
    // reset config: LiPo 1S, default gain, filter at full voltage
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'd4200);

    // gain zero: filter tracks the sample; type write with junk upper bits -> LiPo 4S
    wait_drained();
    write_reg(bvm_pkg::CfgFilterGain, 16'h0000);
    write_reg(bvm_pkg::CfgBatteryType, 16'hFFFB);
    send_sample(16'd12799);   // just below low voltage
    send_sample(16'd12800);   // exactly low voltage
    send_sample(16'd16800);   // full voltage
    send_sample(16'hFFFF);

    // LiFe 1S around its thresholds, plus a zero sample (most negative level)
    wait_drained();
    write_reg(bvm_pkg::CfgBatteryType, 16'h0004);
    send_sample(16'd2999);
    send_sample(16'd3000);
    send_sample(16'd3600);
    send_sample(16'h0000);

    // maximum gain: sample barely moves the state; LiFe 4S
    wait_drained();
    write_reg(bvm_pkg::CfgFilterGain, 16'hFFFF);
    write_reg(bvm_pkg::CfgBatteryType, 16'h0007);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h0000);

    // smallest nonzero gain
    wait_drained();
    write_reg(bvm_pkg::CfgFilterGain, 16'h0001);
    send_sample(16'hFFFF);
    send_sample(16'h0000);

    // gain write alone must leave the filter state alone
    wait_drained();
    write_reg(bvm_pkg::CfgFilterGain, 16'h8000);
    send_sample(16'd5000);
    send_sample(16'd5000);

    // ---- random: four handshake mixes, four config segments each ----
    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      idle_pct  = sender_idle[ph];
      stall_pct <= recv_stall[ph];
      for (int seg = 0; seg < 4; seg++) begin
        wait_drained();
        // type write is skipped now and then so the state carries over
        if ($urandom_range(2) != 0) write_reg(bvm_pkg::CfgBatteryType, 16'($urandom));
        roll = $urandom_range(3);
        if (roll == 0)      gain = 16'h0000;
        else if (roll == 1) gain = 16'hFFFF;
        else                gain = 16'($urandom);
        write_reg(bvm_pkg::CfgFilterGain, gain);
        // back-pressure burst while the sender runs flat out
        if (ph == 0 && seg == 1) hold_req <= ~hold_req;
        for (int k = 0; k < SegItems; k++) begin
          roll = $urandom_range(7);
          if (roll == 0)      mv = 16'($urandom);
          else if (roll == 1) mv = ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
          else                mv = 16'($urandom_range(17500, 2500));  // around pack range
          send_sample(mv);
        end
      end
    end

    wait_drained();
    repeat (16) @(posedge clk_i);   // back end latency margin for stray readings

    $display("summary: %0d samples under four handshake mixes, %0d readings checked",
             n_sent, checked_cnt);
    $display("summary: %0d register writes incl. gain extremes, one %0d-cycle output hold",
             n_writes, HoldCycles);
    if (mismatch_cnt == 0 && pending == 0) begin
      $display("battery_voltage_monitor regression: pass");
    end else begin
      $display("%0d mismatches, %0d readings never arrived", mismatch_cnt, pending);
      $display("battery_voltage_monitor regression: fail");
    end
    $finish;
  end

endmodule
